// ----- src/tabl_pkg.sv -----
// Shared types and constants for the timed address blocklist.
package tabl_pkg;

    localparam int TIME_W = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // action codes
    localparam logic [2:0] ACT_BLOCK_PERM  = 3'd0;
    localparam logic [2:0] ACT_BLOCK_TIMED = 3'd1;
    localparam logic [2:0] ACT_UNBLOCK     = 3'd2;
    localparam logic [2:0] ACT_QUERY       = 3'd3;
    localparam logic [2:0] ACT_SWEEP       = 3'd4;
    localparam logic [2:0] ACT_TICK        = 3'd5;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] block_ticks;
    } t_in_beat;

    typedef struct packed {
        logic       blocked;
        logic [1:0] status;
        logic [6:0] removed_count;
        logic [6:0] entry_count;
    } t_out_beat;

    typedef struct packed {
        logic              valid;
        logic              permanent;
        logic [31:0]       address;
        logic [15:0]       port_number;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic free;
        logic expired;
    } t_cmp;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_WRITE
    } t_state;

endpackage

// ----- src/tabl_mem.sv -----
// Entry table memory: one write port, one registered read port.
module tabl_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  tabl_pkg::t_entry         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output tabl_pkg::t_entry         o_rd_data
);

    tabl_pkg::t_entry r_mem [DEPTH];
    tabl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/tabl_cmp.sv -----
// Shared compare unit: key match, free slot and expiry test for one entry.
module tabl_cmp (
    input  tabl_pkg::t_entry               i_entry,
    input  logic [31:0]                    i_ip,
    input  logic [15:0]                    i_port,
    input  logic [tabl_pkg::TIME_W-1:0]    i_now,
    output tabl_pkg::t_cmp                 o_cmp
);

    always_comb begin
        o_cmp.hit     = i_entry.valid && (i_entry.address == i_ip)
                        && (i_entry.port_number == i_port);
        o_cmp.free    = !i_entry.valid;
        o_cmp.expired = i_entry.valid && !i_entry.permanent && (i_now >= i_entry.expiry);
    end

endmodule

// ----- src/timed_address_blocklist_unit.sv -----
// Block, unblock, query and sweep scan the whole table before the result is registered; tick
// and unknown actions go straight to the result.
// A new item is taken only once the result of the last one is registered; the scan of the
// one-port table sets the rate.
// Reset: time and count go to zero, then a clearing pass invalidates every entry while the
// input stalls.
module timed_address_blocklist_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tabl_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tabl_pkg::t_out_beat o_out_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int IW = AW + 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [IW-1:0] END_IDX  = IW'(TABLE_ENTRIES);

    tabl_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_idx;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    tabl_pkg::t_in_beat r_item;
    logic [tabl_pkg::TIME_W-1:0] r_time, n_time;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_removed;
    logic             r_hit, r_hit_exp, r_free_found;
    logic [AW-1:0]    r_hit_idx, r_free_idx;
    logic             r_out_vld;
    tabl_pkg::t_out_beat r_out;

    logic             w_accept;
    logic             w_out_free;
    logic             w_in_scan;
    logic             w_is_lookup;
    logic             w_is_sweep;
    logic             w_sweep_hit;
    logic             w_cnt_inc, w_cnt_dec;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    tabl_pkg::t_entry w_wr_data;
    tabl_pkg::t_entry w_rd_entry;
    tabl_pkg::t_cmp   w_cmp;
    tabl_pkg::t_out_beat w_res;
    logic [tabl_pkg::TIME_W:0]   w_sum;
    logic [tabl_pkg::TIME_W-1:0] w_exp;
    logic [31:0]      w_cnt_wide, w_rem_wide;

    tabl_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_entry)
    );

    tabl_cmp u_cmp (
        .i_entry (w_rd_entry),
        .i_ip    (r_item.client_ip),
        .i_port  (r_item.client_port),
        .i_now   (r_time),
        .o_cmp   (w_cmp)
    );

    assign o_in_stall = (r_state != tabl_pkg::FSM_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_in_scan  = i_in_data.action inside {tabl_pkg::ACT_BLOCK_PERM,
                                                 tabl_pkg::ACT_BLOCK_TIMED,
                                                 tabl_pkg::ACT_UNBLOCK,
                                                 tabl_pkg::ACT_QUERY,
                                                 tabl_pkg::ACT_SWEEP};
    assign w_is_lookup = r_item.action inside {tabl_pkg::ACT_BLOCK_PERM,
                                               tabl_pkg::ACT_BLOCK_TIMED,
                                               tabl_pkg::ACT_UNBLOCK,
                                               tabl_pkg::ACT_QUERY};
    assign w_is_sweep  = (r_item.action == tabl_pkg::ACT_SWEEP);
    assign w_sweep_hit = (r_state == tabl_pkg::FSM_SCAN) && r_rd_vld && w_is_sweep
                         && w_cmp.expired;

    // saturate expiry at the top of the time range
    assign w_sum = {1'b0, r_time} + (tabl_pkg::TIME_W + 1)'(r_item.block_ticks);
    assign w_exp = w_sum[tabl_pkg::TIME_W] ? tabl_pkg::TIME_MAX
                                           : w_sum[tabl_pkg::TIME_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tabl_pkg::FSM_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = tabl_pkg::FSM_IDLE;
                end
            end
            tabl_pkg::FSM_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_in_scan ? tabl_pkg::FSM_SCAN : tabl_pkg::FSM_WRITE;
                end
            end
            tabl_pkg::FSM_SCAN: begin
                if (r_idx == END_IDX) begin
                    n_state = tabl_pkg::FSM_WRITE;
                end
            end
            tabl_pkg::FSM_WRITE: begin
                if (w_out_free) begin
                    n_state = tabl_pkg::FSM_IDLE;
                end
            end
            default: n_state = tabl_pkg::FSM_IDLE;
        endcase
    end

    // table writes and the result of the item
    always_comb begin
        w_wr_en             = 1'b0;
        w_wr_addr           = r_rd_idx;
        w_wr_data           = w_rd_entry;
        w_wr_data.valid     = 1'b0;
        w_cnt_inc           = 1'b0;
        w_cnt_dec           = 1'b0;
        w_res.blocked       = 1'b0;
        w_res.status        = tabl_pkg::STS_OK;
        case (r_state)
            tabl_pkg::FSM_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx[AW-1:0];
                w_wr_data = '0;
            end
            tabl_pkg::FSM_SCAN: begin
                // drop expired entries as the sweep passes them
                if (w_sweep_hit) begin
                    w_wr_en   = 1'b1;
                    w_cnt_dec = 1'b1;
                end
            end
            tabl_pkg::FSM_WRITE: begin
                case (r_item.action)
                    tabl_pkg::ACT_BLOCK_PERM, tabl_pkg::ACT_BLOCK_TIMED: begin
                        w_wr_data.valid       = 1'b1;
                        w_wr_data.permanent   = (r_item.action == tabl_pkg::ACT_BLOCK_PERM);
                        w_wr_data.address     = r_item.client_ip;
                        w_wr_data.port_number = r_item.client_port;
                        w_wr_data.expiry      = (r_item.action == tabl_pkg::ACT_BLOCK_PERM)
                                                ? '0 : w_exp;
                        if (r_hit) begin
                            w_wr_en   = w_out_free;
                            w_wr_addr = r_hit_idx;
                        end else if (r_free_found) begin
                            w_wr_en   = w_out_free;
                            w_wr_addr = r_free_idx;
                            w_cnt_inc = w_out_free;
                        end else begin
                            w_res.status = tabl_pkg::STS_FULL;
                        end
                    end
                    tabl_pkg::ACT_UNBLOCK: begin
                        w_wr_addr = r_hit_idx;
                        w_wr_data = '0;
                        if (r_hit) begin
                            w_wr_en   = w_out_free;
                            w_cnt_dec = w_out_free;
                        end else begin
                            w_res.status = tabl_pkg::STS_NOT_FOUND;
                        end
                    end
                    tabl_pkg::ACT_QUERY: begin
                        w_wr_addr = r_hit_idx;
                        w_wr_data = '0;
                        if (!r_hit) begin
                            w_res.status = tabl_pkg::STS_NOT_FOUND;
                        end else if (r_hit_exp) begin
                            w_wr_en   = w_out_free;
                            w_cnt_dec = w_out_free;
                        end else begin
                            w_res.blocked = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (w_cnt_dec && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end
        n_time = r_time;
        if ((r_state == tabl_pkg::FSM_WRITE) && w_out_free
            && (r_item.action == tabl_pkg::ACT_TICK) && (r_time != tabl_pkg::TIME_MAX)) begin
            n_time = r_time + tabl_pkg::TIME_W'(1);
        end
    end

    assign w_cnt_wide = 32'(n_count);
    assign w_rem_wide = 32'(r_removed);
    assign w_res.removed_count = w_rem_wide[6:0];
    assign w_res.entry_count   = w_cnt_wide[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tabl_pkg::FSM_CLEAR;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_time       <= '0;
            r_count      <= '0;
            r_removed    <= '0;
            r_hit        <= 1'b0;
            r_hit_exp    <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_time   <= n_time;
            r_count  <= n_count;
            r_rd_vld <= (r_state == tabl_pkg::FSM_SCAN) && (r_idx != END_IDX);
            case (r_state)
                tabl_pkg::FSM_CLEAR: begin
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                tabl_pkg::FSM_IDLE: begin
                    if (w_accept) begin
                        r_idx        <= '0;
                        r_removed    <= '0;
                        r_hit        <= 1'b0;
                        r_hit_exp    <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                tabl_pkg::FSM_SCAN: begin
                    if (r_idx != END_IDX) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    if (r_rd_vld && w_is_lookup) begin
                        // keep the lowest match and the lowest free slot
                        if (w_cmp.hit && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_exp <= w_cmp.expired;
                        end
                        if (w_cmp.free && !r_free_found) begin
                            r_free_found <= 1'b1;
                        end
                    end
                    if (w_sweep_hit) begin
                        r_removed <= r_removed + CW'(1);
                    end
                end
                default: begin
                end
            endcase
            if ((r_state == tabl_pkg::FSM_WRITE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[AW-1:0];
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if ((r_state == tabl_pkg::FSM_SCAN) && r_rd_vld && w_is_lookup) begin
            if (w_cmp.hit && !r_hit) begin
                r_hit_idx <= r_rd_idx;
            end
            if (w_cmp.free && !r_free_found) begin
                r_free_idx <= r_rd_idx;
            end
        end
        if ((r_state == tabl_pkg::FSM_WRITE) && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the timed address blocklist unit: directed and random beats.
`timescale 1ns / 1ps
module tb_top;

    localparam int TABLE_N    = 64;
    localparam int POOL_N     = 96;
    localparam int ITEM_GOAL  = 1750;
    localparam int TAIL_BEATS = 150;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct {
        tabl_pkg::t_in_beat beat;
        bit                 drain_first;
    } t_request;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    tabl_pkg::t_in_beat  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    tabl_pkg::t_out_beat o_out_data;

    timed_address_blocklist_unit #(
        .TABLE_ENTRIES(TABLE_N)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the blocklist table
    bit          tbl_valid  [TABLE_N];
    logic [31:0] tbl_ip     [TABLE_N];
    logic [15:0] tbl_port   [TABLE_N];
    bit          tbl_perm   [TABLE_N];
    logic [47:0] tbl_expiry [TABLE_N];
    logic [47:0] now_ticks  = '0;
    int unsigned live_count = 0;

    t_request            queued_requests[$];
    tabl_pkg::t_out_beat awaited_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned planned_items  = 0;
    bit          drain_pending  = 1'b0;

    logic [31:0] pool_ip   [POOL_N];
    logic [15:0] pool_port [POOL_N];

    int unsigned send_gap    = 0;
    int unsigned send_window = 0;
    bit          send_idles  = 1'b1;
    int unsigned stall_left  = 0;
    int unsigned stall_window = 0;
    bit          stall_idles = 1'b1;

    function automatic bit is_lapsed(int slot);
        return !tbl_perm[slot] && (now_ticks >= tbl_expiry[slot]);
    endfunction

    // Apply one beat to the shadow table and return the verdict it should produce.
    function automatic tabl_pkg::t_out_beat apply_blocklist_action(tabl_pkg::t_in_beat b);
        tabl_pkg::t_out_beat r;
        int          slot;
        int          free_slot;
        int unsigned swept;
        logic [48:0] reach;
        r         = '0;
        slot      = -1;
        free_slot = -1;
        swept     = 0;
        for (int k = 0; k < TABLE_N; k++) begin
            if (slot < 0 && tbl_valid[k] && tbl_ip[k] == b.client_ip &&
                tbl_port[k] == b.client_port)
                slot = k;
            if (free_slot < 0 && !tbl_valid[k])
                free_slot = k;
        end
        case (b.action)
            tabl_pkg::ACT_BLOCK_PERM, tabl_pkg::ACT_BLOCK_TIMED: begin
                if (slot < 0) begin
                    if (free_slot < 0) begin
                        r.status = tabl_pkg::STS_FULL;
                    end else begin
                        slot             = free_slot;
                        tbl_valid[slot]  = 1'b1;
                        tbl_ip[slot]     = b.client_ip;
                        tbl_port[slot]   = b.client_port;
                        live_count++;
                    end
                end
                if (slot >= 0) begin
                    if (b.action == tabl_pkg::ACT_BLOCK_PERM) begin
                        tbl_perm[slot]   = 1'b1;
                        tbl_expiry[slot] = '0;
                    end else begin
                        reach            = {1'b0, now_ticks} + {17'b0, b.block_ticks};
                        tbl_perm[slot]   = 1'b0;
                        tbl_expiry[slot] = reach[48] ? tabl_pkg::TIME_MAX : reach[47:0];
                    end
                end
            end
            tabl_pkg::ACT_UNBLOCK: begin
                if (slot < 0) begin
                    r.status = tabl_pkg::STS_NOT_FOUND;
                end else begin
                    tbl_valid[slot] = 1'b0;
                    if (live_count > 0) live_count--;
                end
            end
            tabl_pkg::ACT_QUERY: begin
                if (slot < 0) begin
                    r.status = tabl_pkg::STS_NOT_FOUND;
                end else if (is_lapsed(slot)) begin
                    tbl_valid[slot] = 1'b0;
                    if (live_count > 0) live_count--;
                end else begin
                    r.blocked = 1'b1;
                end
            end
            tabl_pkg::ACT_SWEEP: begin
                for (int k = 0; k < TABLE_N; k++) begin
                    if (tbl_valid[k] && is_lapsed(k)) begin
                        tbl_valid[k] = 1'b0;
                        if (live_count > 0) live_count--;
                        swept++;
                    end
                end
            end
            tabl_pkg::ACT_TICK: begin
                if (now_ticks != tabl_pkg::TIME_MAX) now_ticks = now_ticks + 1'b1;
            end
            default: ;
        endcase
        r.removed_count = swept[6:0];
        r.entry_count   = live_count[6:0];
        return r;
    endfunction

    task automatic judge_verdict(input tabl_pkg::t_out_beat got);
        tabl_pkg::t_out_beat want;
        if (awaited_verdicts.size() == 0) begin
            if (mismatch_count < 10)
                $display("%0t: unexpected result: blocked=%0d status=%0d removed=%0d count=%0d",
                         $time, got.blocked, got.status, got.removed_count, got.entry_count);
            mismatch_count++;
            return;
        end
        want = awaited_verdicts.pop_front();
        if (got.blocked !== want.blocked || got.status !== want.status ||
            got.removed_count !== want.removed_count || got.entry_count !== want.entry_count) begin
            if (mismatch_count < 10)
                $display("%0t: blocked/status/removed/count exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                         $time, want.blocked, want.status, want.removed_count, want.entry_count,
                         got.blocked, got.status, got.removed_count, got.entry_count);
            mismatch_count++;
        end
    endtask

    task automatic queue_request(input logic [2:0] act, input logic [31:0] ip,
                                 input logic [15:0] port, input logic [31:0] ticks);
        t_request r;
        r.beat.action      = act;
        r.beat.client_ip   = ip;
        r.beat.client_port = port;
        r.beat.block_ticks = ticks;
        r.drain_first      = drain_pending;
        drain_pending      = 1'b0;
        queued_requests.insert(queued_requests.size(), r);
        if (act <= tabl_pkg::ACT_TICK) planned_items++;
    endtask

    // Mostly short durations so entries lapse within the run, some full-width.
    function automatic logic [31:0] pick_ticks();
        return ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
    endfunction

    function automatic logic [15:0] pick_port();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Sender: present queued beats, hold each until accepted.
    always @(posedge i_clk) begin
        logic               next_valid;
        tabl_pkg::t_in_beat next_data;
        bit                 quiet;
        next_valid = i_in_valid;
        next_data  = i_in_data;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            quiet = queued_requests.size() <= TAIL_BEATS;
            if (send_window == 0) begin
                send_window = $urandom_range(200, 1500);
                send_idles  = ($urandom_range(0, 2) != 0);
            end else begin
                send_window--;
            end
            if (i_in_valid && !o_in_stall) begin
                awaited_verdicts.insert(awaited_verdicts.size(),
                                        apply_blocklist_action(i_in_data));
                void'(queued_requests.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (queued_requests.size() != 0 &&
                             !(queued_requests[0].drain_first &&
                               awaited_verdicts.size() != 0)) begin
                    if (send_idles && !quiet && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(0, 12);
                    end else begin
                        next_valid = 1'b1;
                        next_data  = queued_requests[0].beat;
                    end
                end
            end
        end
        i_in_valid <= next_valid;
        i_in_data  <= next_data;
    end

    // Receiver: check each accepted result and stall in bursts.
    always @(posedge i_clk) begin
        bit quiet;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            quiet = queued_requests.size() <= TAIL_BEATS;
            if (o_out_valid && !i_out_stall)
                judge_verdict(o_out_data);
            if (stall_window == 0) begin
                stall_window = $urandom_range(200, 1500);
                stall_idles  = ($urandom_range(0, 2) != 0);
            end else begin
                stall_window--;
            end
            if (stall_left != 0)
                stall_left--;
            else if (stall_idles && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
            i_out_stall <= (stall_left != 0);
        end
    end

    initial begin
        int          pick;
        int          base;
        int          episode;
        int          roll;
        int          burst;
        logic [31:0] ip;
        logic [15:0] port;

        for (int k = 0; k < POOL_N; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = pick_port();
        end
        pool_ip[0]   = '0;
        pool_port[0] = '0;
        pool_ip[1]   = '1;
        pool_port[1] = '1;
        // same address on another port, and same port on another address
        pool_ip[3]   = pool_ip[2];
        pool_port[3] = ~pool_port[2];
        pool_ip[5]   = ~pool_ip[4];
        pool_port[5] = pool_port[4];

        // directed opening
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[0], pool_port[0], '1);
        queue_request(tabl_pkg::ACT_UNBLOCK,     pool_ip[1], pool_port[1], '0);
        queue_request(tabl_pkg::ACT_BLOCK_PERM,  pool_ip[0], pool_port[0], '1);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[1], pool_port[1], 32'hFFFF_FFFF);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[2], pool_port[2], 32'd0);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[3], pool_port[3], 32'd2);
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[0], pool_port[0], '0);
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[2], pool_port[2], '0);
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[3], pool_port[3], '0);
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[5], pool_port[5], '0);
        queue_request(tabl_pkg::ACT_TICK,        '1,         '1,           '1);
        queue_request(tabl_pkg::ACT_TICK,        '0,         '0,           '0);
        queue_request(tabl_pkg::ACT_SWEEP,       '0,         '0,           '0);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[4], pool_port[4], 32'd0);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[5], pool_port[5], 32'd0);
        queue_request(tabl_pkg::ACT_SWEEP,       '1,         '1,           '1);
        queue_request(tabl_pkg::ACT_BLOCK_TIMED, pool_ip[0], pool_port[0], 32'd5);
        queue_request(tabl_pkg::ACT_BLOCK_PERM,  pool_ip[1], pool_port[1], '0);
        queue_request(tabl_pkg::ACT_UNBLOCK,     pool_ip[0], pool_port[0], '0);
        queue_request(ACT_SPARE_6,               $urandom,   16'h5A5A,     $urandom);
        queue_request(ACT_SPARE_7,               '1,         '1,           '1);
        queue_request(tabl_pkg::ACT_QUERY,       pool_ip[1], pool_port[1], '0);
        queue_request(tabl_pkg::ACT_SWEEP,       '0,         '0,           '0);

        // wait for the opening to drain before the random part
        drain_pending = 1'b1;
        while (planned_items < ITEM_GOAL) begin
            episode = $urandom_range(0, 39);
            if (episode == 0) begin
                // fill the table from the pool and overflow it
                base = $urandom_range(0, POOL_N - 1);
                for (int k = 0; k < TABLE_N + 6; k++) begin
                    pick = (base + k) % POOL_N;
                    queue_request(($urandom_range(0, 1) != 0) ? tabl_pkg::ACT_BLOCK_TIMED
                                                              : tabl_pkg::ACT_BLOCK_PERM,
                                  pool_ip[pick], pool_port[pick], pick_ticks());
                end
            end else if (episode <= 2) begin
                burst = $urandom_range(1, 40);
                repeat (burst) queue_request(tabl_pkg::ACT_TICK, $urandom, pick_port(),
                                             $urandom);
            end else if (episode <= 4) begin
                burst = $urandom_range(5, 20);
                repeat (burst) begin
                    pick = $urandom_range(0, POOL_N - 1);
                    queue_request(tabl_pkg::ACT_UNBLOCK, pool_ip[pick], pool_port[pick],
                                  $urandom);
                end
            end else begin
                if ($urandom_range(0, 79) == 0) drain_pending = 1'b1;
                roll = $urandom_range(0, 99);
                pick = $urandom_range(0, POOL_N - 1);
                ip   = pool_ip[pick];
                port = pool_port[pick];
                if (roll >= 22 && roll < 66 && $urandom_range(0, 7) == 0) begin
                    // address that is most likely absent
                    ip   = $urandom;
                    port = pick_port();
                end
                if (roll < 14)
                    queue_request(tabl_pkg::ACT_BLOCK_TIMED, ip, port, pick_ticks());
                else if (roll < 22)
                    queue_request(tabl_pkg::ACT_BLOCK_PERM, ip, port, $urandom);
                else if (roll < 32)
                    queue_request(tabl_pkg::ACT_UNBLOCK, ip, port, $urandom);
                else if (roll < 66)
                    queue_request(tabl_pkg::ACT_QUERY, ip, port, $urandom);
                else if (roll < 74)
                    queue_request(tabl_pkg::ACT_SWEEP, $urandom, pick_port(), $urandom);
                else if (roll < 98)
                    queue_request(tabl_pkg::ACT_TICK, $urandom, pick_port(), $urandom);
                else
                    queue_request(($urandom_range(0, 1) != 0) ? ACT_SPARE_7 : ACT_SPARE_6,
                                  $urandom, pick_port(), $urandom);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (TABLE_N + 10) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tabl_pkg.sv
src/tabl_mem.sv
src/tabl_cmp.sv
src/timed_address_blocklist_unit.sv
bench/tb_top.sv
